@@ rtl/sca_pkg.sv @@
// ----------------------------------------------------------------------------
// sca_pkg
// Shared types and constants for the slot counter assembler.
// ----------------------------------------------------------------------------
`default_nettype none

package sca_pkg;

  localparam logic [7:0]  CLASS_MASK = 8'hF0;
  localparam logic [7:0]  CLASS_90   = 8'h90;
  localparam logic [7:0]  CLASS_A0   = 8'hA0;
  localparam logic [7:0]  CLASS_B0   = 8'hB0;

  localparam logic [6:0]  SYNC_A0    = 7'h10;
  localparam logic [6:0]  SYNC_LOW   = 7'h20;
  localparam logic [6:0]  SYNC_HIGH  = 7'h40;
  localparam logic [6:0]  SYNC_ALL   = 7'h70;

  localparam logic [15:0] SPAN_MAX   = 16'hFFFF;

  // Frame class as seen by the back end; CRC-bad frames get their own kind.
  typedef enum logic [2:0] {
    KIND_BAD,
    KIND_A0,
    KIND_90,
    KIND_B0,
    KIND_OTHER
  } frame_kind_t;

  typedef struct packed {
    logic [7:0] opcode_byte;
    logic [7:0] body_first;
    logic [7:0] body_second;
    logic       crc_good;
  } in_item_t;

  typedef struct packed {
    logic        counter_complete;
    logic [31:0] slot_value;
    logic [7:0]  counter_top_byte;
    logic        phase_bit;
    logic [31:0] slot_delta;
    logic [15:0] set_span;
    logic [6:0]  sync_mask;
    logic        decrypt_request;
    logic [31:0] heard_count;
    logic [31:0] crc_good_count;
    logic [31:0] crc_bad_count;
  } out_item_t;

  typedef struct packed {
    frame_kind_t kind;
    logic [7:0]  body_first;
    logic [7:0]  body_second;
  } q_item_t;

  // Queue head as presented to the back end.
  typedef struct packed {
    logic    valid;
    q_item_t item;
  } q_head_t;

endpackage

`default_nettype wire

@@ rtl/slot_counter_assembler_core.sv @@
// A transferred frame is queued; the back end pops it and registers its result.
// Throughput: one frame per cycle; the back end retires one queue entry per cycle
// while result_stall is low. The two-entry queue absorbs result stalls until full.
// Reset (rst, synchronous, active high) clears the queue, result valid,
// the assembly stage, counter bytes, slot, delta, span and frame counters.
// ----------------------------------------------------------------------------
// slot_counter_assembler_core
// Frame counter and A0/90/90 packet counter assembler with decrypt trigger.
// ----------------------------------------------------------------------------
`default_nettype none

module slot_counter_assembler_core (
  input  logic               clk,
  input  logic               rst,
  // frame channel
  input  logic               frame_valid,
  output logic               frame_stall,
  input  sca_pkg::in_item_t  frame,
  // result channel
  output logic               result_valid,
  input  logic               result_stall,
  output sca_pkg::out_item_t result
);
  import sca_pkg::*;

  q_head_t head;
  logic    pop;

  // Front: classify by CRC and opcode class, queue the frame. Stall only
  // when both queue entries are occupied.
  sca_front u_front (
    .clk         (clk),
    .rst         (rst),
    .frame_valid (frame_valid),
    .frame_stall (frame_stall),
    .frame       (frame),
    .head        (head),
    .pop         (pop)
  );

  // Back: set assembly, slot/phase/delta, span and frame counters. Each
  // popped frame produces exactly one result transfer.
  sca_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

`default_nettype wire

@@ rtl/sca_front.sv @@
// ----------------------------------------------------------------------------
// sca_front
// Accepts frames, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
`default_nettype none

module sca_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              frame_valid,
  output logic              frame_stall,
  input  sca_pkg::in_item_t frame,
  output sca_pkg::q_head_t  head,
  input  logic              pop
);
  import sca_pkg::*;

  q_item_t     slots [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic [1:0]  count_next;
  logic        push;
  logic [7:0]  cls;
  q_item_t     item;

  always_comb begin
    cls              = frame.opcode_byte & CLASS_MASK;
    item.body_first  = frame.body_first;
    item.body_second = frame.body_second;
    priority if (!frame.crc_good) begin
      item.kind = KIND_BAD;
    end else if (cls == CLASS_A0) begin
      item.kind = KIND_A0;
    end else if (cls == CLASS_90) begin
      item.kind = KIND_90;
    end else if (cls == CLASS_B0) begin
      item.kind = KIND_B0;
    end else begin
      item.kind = KIND_OTHER;
    end
  end

  assign frame_stall = (count == 2'd2);
  assign push        = frame_valid && !frame_stall;

  always_comb begin
    unique case ({push, pop})
      2'b10:   count_next = count + 2'd1;
      2'b01:   count_next = count - 2'd1;
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count_next;
    end
  end

  assign head.valid = (count != 2'd0);
  assign head.item  = slots[rd_ptr];

endmodule

`default_nettype wire

@@ rtl/sca_back.sv @@
// ----------------------------------------------------------------------------
// sca_back
// Runs the set assembler and frame counters; one result register out.
// ----------------------------------------------------------------------------
`default_nettype none

module sca_back (
  input  logic               clk,
  input  logic               rst,
  input  sca_pkg::q_head_t   head,
  output logic               pop,
  output logic               result_valid,
  input  logic               result_stall,
  output sca_pkg::out_item_t result
);
  import sca_pkg::*;

  typedef enum logic [1:0] {
    STAGE_IDLE,
    STAGE_HAVE_A0,
    STAGE_HAVE_LOW
  } stage_t;

  stage_t      stage, stage_next;
  logic [7:0]  byte0, byte0_next;
  logic [7:0]  byte1, byte1_next;
  logic [7:0]  byte2, byte2_next;
  logic [7:0]  top_byte, top_byte_next;
  logic [31:0] slot_reg, slot_reg_next;
  logic [6:0]  progress, progress_next;
  logic        phase, phase_next;
  logic [31:0] prev_slot, prev_slot_next;
  logic        have_prev, have_prev_next;
  logic [15:0] span, span_next;
  logic [31:0] delta, delta_next;
  logic [31:0] heard, good, bad;
  logic [31:0] heard_next, good_next, bad_next;
  logic        complete, request;
  q_item_t     it;

  // Take the queue head whenever the result register is free or draining.
  assign pop = head.valid && (!result_valid || !result_stall);
  assign it  = head.item;

  always_comb begin
    stage_next     = stage;
    byte0_next     = byte0;
    byte1_next     = byte1;
    byte2_next     = byte2;
    top_byte_next  = top_byte;
    slot_reg_next  = slot_reg;
    progress_next  = progress;
    phase_next     = phase;
    prev_slot_next = prev_slot;
    have_prev_next = have_prev;
    span_next      = span;
    delta_next     = delta;
    complete       = 1'b0;
    request        = 1'b0;
    heard_next     = heard + 32'd1;
    good_next      = (it.kind != KIND_BAD) ? good + 32'd1 : good;
    bad_next       = (it.kind == KIND_BAD) ? bad + 32'd1 : bad;

    unique case (it.kind)
      KIND_A0: begin
        byte0_next    = it.body_first;
        stage_next    = STAGE_HAVE_A0;
        progress_next = SYNC_A0;
        span_next     = 16'd0;
      end
      KIND_90: begin
        if (span != SPAN_MAX) begin
          span_next = span + 16'd1;
        end
        unique case (stage)
          STAGE_HAVE_A0: begin
            byte1_next    = it.body_first;
            byte2_next    = it.body_second;
            stage_next    = STAGE_HAVE_LOW;
            progress_next = progress | SYNC_LOW;
          end
          STAGE_HAVE_LOW: begin
            top_byte_next  = it.body_second;
            stage_next     = STAGE_IDLE;
            progress_next  = progress | SYNC_HIGH;
            slot_reg_next  = {it.body_first, byte2, byte1, byte0};
            phase_next     = byte0[0];
            delta_next     = have_prev ? (slot_reg_next - prev_slot) : 32'd0;
            prev_slot_next = slot_reg_next;
            have_prev_next = 1'b1;
            complete       = 1'b1;
          end
          default: begin
            stage_next = STAGE_IDLE;
          end
        endcase
      end
      KIND_B0: begin
        request = ((progress & SYNC_ALL) == SYNC_ALL);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage     <= STAGE_IDLE;
      byte0     <= 8'd0;
      byte1     <= 8'd0;
      byte2     <= 8'd0;
      top_byte  <= 8'd0;
      slot_reg  <= 32'd0;
      progress  <= 7'd0;
      phase     <= 1'b0;
      prev_slot <= 32'd0;
      have_prev <= 1'b0;
      span      <= 16'd0;
      delta     <= 32'd0;
      heard     <= 32'd0;
      good      <= 32'd0;
      bad       <= 32'd0;
      result_valid <= 1'b0;
    end else begin
      if (pop) begin
        stage     <= stage_next;
        byte0     <= byte0_next;
        byte1     <= byte1_next;
        byte2     <= byte2_next;
        top_byte  <= top_byte_next;
        slot_reg  <= slot_reg_next;
        progress  <= progress_next;
        phase     <= phase_next;
        prev_slot <= prev_slot_next;
        have_prev <= have_prev_next;
        span      <= span_next;
        delta     <= delta_next;
        heard     <= heard_next;
        good      <= good_next;
        bad       <= bad_next;
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      result.counter_complete <= complete;
      result.slot_value       <= slot_reg_next;
      result.counter_top_byte <= top_byte_next;
      result.phase_bit        <= phase_next;
      result.slot_delta       <= delta_next;
      result.set_span         <= span_next;
      result.sync_mask        <= progress_next;
      result.decrypt_request  <= request;
      result.heard_count      <= heard_next;
      result.crc_good_count   <= good_next;
      result.crc_bad_count    <= bad_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/sca_checker.sv @@
// ----------------------------------------------------------------------------
// sca_checker
// Port-level checks for slot_counter_assembler_core.
// ----------------------------------------------------------------------------
`default_nettype none

module sca_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               result_valid,
  input  logic               result_stall,
  input  sca_pkg::out_item_t result
);
  import sca_pkg::*;

  // held result must not move
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  a_complete_mask: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.counter_complete |-> result.sync_mask == SYNC_ALL)
    else $error("completion without full sync mask");

  a_request_mask: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.decrypt_request |->
      result.sync_mask == SYNC_ALL && !result.counter_complete)
    else $error("decrypt request without sync");

  a_totals: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.heard_count == result.crc_good_count + result.crc_bad_count)
    else $error("frame totals disagree");

endmodule

bind slot_counter_assembler_core sca_checker u_sca_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

`default_nettype wire

@@ verif/slot_counter_assembler_core_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slot_counter_assembler_core_test
// Self-checking bench for the frame counter and A0/90/90 counter assembler.
// A queue-fed driver offers frames with random gaps. A monitor predicts every
// transferred frame and checks each result transfer field by field against
// the oldest prediction. The run covers directed corner frames, random
// well-formed and broken sets and a long receiver hold-off.
// ----------------------------------------------------------------------------

module slot_counter_assembler_core_test;
  import sca_pkg::*;

  // Run shape
  localparam int RANDOM_FRAMES  = 1525;   // random part, after the directed frames
  localparam int IDLE_PCT       = 29;     // chance of a gap or a stall per cycle
  localparam int CALM_START     = 1200;   // cycle window with no gaps and no stalls
  localparam int CALM_END       = 1800;
  localparam int HOLDOFF_AT     = 600;    // frames transferred before the long stall
  localparam int HOLDOFF_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 2000;   // cycles with no transfer on either side
  localparam int DRAIN_CYCLES   = 20;     // margin for the 2-entry queue and the result register

  // Assembly stage of the predictor; 3 is unused
  typedef enum logic [1:0] {
    STAGE_IDLE,
    STAGE_HAVE_A0,
    STAGE_HAVE_LOW
  } asm_stage_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       frame_valid = 1'b0;
  logic       frame_stall;
  in_item_t   frame = '0;
  logic       result_valid;
  logic       result_stall = 1'b0;
  out_item_t  result;

  slot_counter_assembler_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .frame_valid  (frame_valid),
    .frame_stall  (frame_stall),
    .frame        (frame),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  in_item_t   pending_frames[$];    // frames still to be offered
  out_item_t  expected_results[$];  // predictions waiting for their result
  int         frame_total;
  int         frames_sent   = 0;
  int         results_seen  = 0;
  int         mismatches    = 0;
  int         idle_cycles   = 0;
  int         cycle_cnt     = 0;
  int         holdoff_left  = 0;
  bit         holdoff_done  = 1'b0;
  bit         moved;

  // Coverage tallies, taken from the predictions
  int         sets_done     = 0;
  int         requests_done = 0;

  // Calm window: neither side idles here
  wire calm = (cycle_cnt >= CALM_START) && (cycle_cnt < CALM_END);

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  // --------------------------------------------------------------------------
  // Predictor state, mirrors the block's registers
  // --------------------------------------------------------------------------
  asm_stage_t  asm_stage;
  logic [7:0]  cnt_bytes [5];
  logic [31:0] slot_q;
  logic [6:0]  mask_q;
  logic        phase_q;
  logic [31:0] prev_slot;
  logic        prev_valid;
  logic [15:0] span_q;
  logic [31:0] delta_q;
  logic [31:0] heard_q;
  logic [31:0] good_q;
  logic [31:0] bad_q;

  task automatic clear_prediction();
    asm_stage  = STAGE_IDLE;
    for (int i = 0; i < 5; i++) cnt_bytes[i] = '0;
    slot_q     = '0;
    mask_q     = '0;
    phase_q    = 1'b0;
    prev_slot  = '0;
    prev_valid = 1'b0;
    span_q     = '0;
    delta_q    = '0;
    heard_q    = '0;
    good_q     = '0;
    bad_q      = '0;
  endtask

  // Advance the predictor by one frame and return the result it must produce.
  function automatic out_item_t predict_frame(in_item_t f);
    out_item_t  r;
    logic [7:0] cls;
    logic       done;
    logic       req;

    r    = '0;
    cls  = f.opcode_byte & CLASS_MASK;
    done = 1'b0;
    req  = 1'b0;

    heard_q = heard_q + 32'd1;
    if (f.crc_good) good_q = good_q + 32'd1;
    else            bad_q  = bad_q + 32'd1;

    // CRC-bad frames touch nothing but the frame counters
    if (f.crc_good && (cls == CLASS_A0 || cls == CLASS_90)) begin
      if (span_q != SPAN_MAX) span_q = span_q + 16'd1;
      if (cls == CLASS_A0) begin
        // A0 always restarts the set, even mid-assembly
        cnt_bytes[0] = f.body_first;
        asm_stage    = STAGE_HAVE_A0;
        mask_q       = SYNC_A0;
        span_q       = '0;
      end else begin
        case (asm_stage)
          STAGE_HAVE_A0: begin
            cnt_bytes[1] = f.body_first;
            cnt_bytes[2] = f.body_second;
            asm_stage    = STAGE_HAVE_LOW;
            mask_q       = mask_q | SYNC_LOW;
          end
          STAGE_HAVE_LOW: begin
            cnt_bytes[3] = f.body_first;
            cnt_bytes[4] = f.body_second;
            asm_stage    = STAGE_IDLE;
            mask_q       = mask_q | SYNC_HIGH;
            slot_q       = {cnt_bytes[3], cnt_bytes[2], cnt_bytes[1], cnt_bytes[0]};
            phase_q      = cnt_bytes[0][0];
            // no previous slot yet: delta reads zero
            delta_q      = prev_valid ? (slot_q - prev_slot) : 32'd0;
            prev_slot    = slot_q;
            prev_valid   = 1'b1;
            done         = 1'b1;
          end
          default: begin
            // 90 while idle only moves the span
          end
        endcase
      end
    end else if (f.crc_good && cls == CLASS_B0) begin
      req = ((mask_q & SYNC_ALL) == SYNC_ALL);
    end

    r.counter_complete = done;
    r.slot_value       = slot_q;
    r.counter_top_byte = cnt_bytes[4];
    r.phase_bit        = phase_q;
    r.slot_delta       = delta_q;
    r.set_span         = span_q;
    r.sync_mask        = mask_q;
    r.decrypt_request  = req;
    r.heard_count      = heard_q;
    r.crc_good_count   = good_q;
    r.crc_bad_count    = bad_q;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("MISMATCH result %0d field %s: expected %h, actual %h",
                 results_seen, name, want, got);
    end
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (expected_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("MISMATCH result %0d arrived with no frame pending: %h",
                 results_seen, got);
    end else begin
      want = expected_results.pop_front();
      check_field("counter_complete", 32'(got.counter_complete), 32'(want.counter_complete));
      check_field("slot_value",       got.slot_value,            want.slot_value);
      check_field("counter_top_byte", 32'(got.counter_top_byte), 32'(want.counter_top_byte));
      check_field("phase_bit",        32'(got.phase_bit),        32'(want.phase_bit));
      check_field("slot_delta",       got.slot_delta,            want.slot_delta);
      check_field("set_span",         32'(got.set_span),         32'(want.set_span));
      check_field("sync_mask",        32'(got.sync_mask),        32'(want.sync_mask));
      check_field("decrypt_request",  32'(got.decrypt_request),  32'(want.decrypt_request));
      check_field("heard_count",      got.heard_count,           want.heard_count);
      check_field("crc_good_count",   got.crc_good_count,        want.crc_good_count);
      check_field("crc_bad_count",    got.crc_bad_count,         want.crc_bad_count);
    end
    results_seen++;
  endtask

  // --------------------------------------------------------------------------
  // Driver: one frame in flight on the port; a stalled frame is held as is.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      frame_valid <= 1'b0;
    end else if (!(frame_valid && frame_stall)) begin
      if (pending_frames.size() != 0 &&
          !(!calm && $urandom_range(0, 99) < IDLE_PCT)) begin
        frame_valid <= 1'b1;
        frame       <= pending_frames.pop_front();
      end else begin
        frame_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: checks the result transfer first, then predicts the frame
  // transfer of the same edge, so a result given on its own frame's edge can never match.
  // It also owns the receiver stall, the hold-off and the watchdog count.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      moved = 1'b0;
      if (result_valid && !result_stall) begin
        moved = 1'b1;
        check_result(result);
      end
      if (frame_valid && !frame_stall) begin
        moved = 1'b1;
        expected_results.push_back(predict_frame(frame));
        if (expected_results[$].counter_complete) sets_done++;
        if (expected_results[$].decrypt_request)  requests_done++;
        frames_sent++;
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;

      // One long hold-off: the sender keeps offering until the queue is full
      if (!holdoff_done && frames_sent >= HOLDOFF_AT) begin
        holdoff_done = 1'b1;
        holdoff_left = HOLDOFF_CYCLES;
      end
      if (holdoff_left != 0) begin
        holdoff_left--;
        result_stall <= 1'b1;
      end else begin
        result_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // Class frame with a random low nibble on the opcode
  task automatic push_frame(input logic [7:0] cls, input logic [7:0] b1,
                            input logic [7:0] b2, input logic good);
    in_item_t f;
    f.opcode_byte = cls | 8'($urandom_range(0, 15));
    f.body_first  = b1;
    f.body_second = b2;
    f.crc_good    = good;
    pending_frames.push_back(f);
  endtask

  // Exact frame, for the directed part
  task automatic push_exact(input logic [7:0] opc, input logic [7:0] b1,
                            input logic [7:0] b2, input logic good);
    in_item_t f;
    f.opcode_byte = opc;
    f.body_first  = b1;
    f.body_second = b2;
    f.crc_good    = good;
    pending_frames.push_back(f);
  endtask

  // Opcode whose class the assembler ignores
  function automatic logic [7:0] other_opcode();
    logic [7:0] opc;
    do begin
      opc = 8'($urandom_range(0, 255));
    end while ((opc & CLASS_MASK) == CLASS_90 || (opc & CLASS_MASK) == CLASS_A0 ||
               (opc & CLASS_MASK) == CLASS_B0);
    return opc;
  endfunction

  task automatic push_noise();
    push_exact(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
               8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [39:0] run_cnt;
    int          base;
    int          pick;

    clear_prediction();
    run_cnt = '0;

    // Directed corners
    push_exact(8'hB0, 8'h00, 8'h00, 1'b1);  // request with empty mask: none
    push_exact(8'h90, 8'h12, 8'h34, 1'b1);  // 90 while idle: span only
    push_exact(8'hB0, 8'hFF, 8'hFF, 1'b0);  // bad B0
    push_exact(8'hA0, 8'hFF, 8'hFF, 1'b0);  // bad A0 is dropped
    push_exact(8'h00, 8'h00, 8'h00, 1'b1);  // other class, all zeros
    push_exact(8'hFF, 8'hFF, 8'hFF, 1'b1);  // other class, all ones
    push_exact(8'hA0, 8'hFF, 8'h00, 1'b1);
    push_exact(8'h90, 8'h00, 8'h00, 1'b0);  // bad frame mid-set is ignored
    push_exact(8'h9F, 8'hFF, 8'hFF, 1'b1);
    push_exact(8'hB0, 8'h00, 8'h00, 1'b1);  // partial mask: no request
    push_exact(8'h90, 8'hFF, 8'hFF, 1'b1);  // first completion, delta zero
    push_exact(8'hBF, 8'h00, 8'h00, 1'b1);  // request
    push_exact(8'hB0, 8'h00, 8'h00, 1'b0);  // bad B0: no request
    push_exact(8'h90, 8'h55, 8'hAA, 1'b1);  // idle again: span only
    push_exact(8'hAF, 8'h00, 8'hFF, 1'b1);
    push_exact(8'h90, 8'h00, 8'h00, 1'b1);
    push_exact(8'h90, 8'h00, 8'h00, 1'b1);  // slot 0, delta wraps to 1
    push_exact(8'hA0, 8'h01, 8'h00, 1'b1);
    push_exact(8'hA0, 8'h02, 8'h00, 1'b1);  // A0 restarts the set
    push_exact(8'h90, 8'h00, 8'h00, 1'b1);
    push_exact(8'hA0, 8'h03, 8'h00, 1'b1);  // broken set, restart mid-way
    push_exact(8'h90, 8'h55, 8'hAA, 1'b1);
    push_exact(8'h90, 8'hAA, 8'h55, 1'b1);
    push_exact(8'hB5, 8'h00, 8'h00, 1'b1);
    push_exact(8'h5A, 8'hA5, 8'h5A, 1'b1);

    // Random part: mostly well-formed sets, plus noise and broken sets
    base = pending_frames.size();
    while (pending_frames.size() < base + RANDOM_FRAMES) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        // Counter either steps forward a little or jumps anywhere
        if ($urandom_range(0, 1)) begin
          run_cnt = run_cnt + 40'($urandom_range(1, 4));
        end else begin
          run_cnt[31:0]  = $urandom;
          run_cnt[39:32] = 8'($urandom_range(0, 255));
        end
        push_frame(CLASS_A0, run_cnt[7:0], 8'($urandom_range(0, 255)), 1'b1);
        if ($urandom_range(0, 9) == 0) push_noise();
        push_frame(CLASS_90, run_cnt[15:8], run_cnt[23:16], 1'b1);
        if ($urandom_range(0, 9) == 0) push_noise();
        push_frame(CLASS_90, run_cnt[31:24], run_cnt[39:32], 1'b1);
        repeat ($urandom_range(0, 2))
          push_frame(CLASS_B0, 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)), 1'b1);
      end else if (pick < 80) begin
        push_noise();
      end else begin
        // Broken set: A0, maybe one 90, then something that is not the next 90
        push_frame(CLASS_A0, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b1);
        if ($urandom_range(0, 1))
          push_frame(CLASS_90, 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)), 1'b1);
        case ($urandom_range(0, 2))
          0: push_frame(CLASS_B0, 8'($urandom_range(0, 255)),
                        8'($urandom_range(0, 255)), 1'b1);
          1: push_exact(other_opcode(), 8'($urandom_range(0, 255)),
                        8'($urandom_range(0, 255)), 1'b1);
          default: push_frame(CLASS_A0, 8'($urandom_range(0, 255)),
                              8'($urandom_range(0, 255)), 1'b1);
        endcase
      end
    end
    frame_total = pending_frames.size();

    // Hold reset, then release it on an edge like any other input
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Sample on the falling edge, clear of the monitor's updates
    @(negedge clk);
    while (!(frames_sent == frame_total && expected_results.size() == 0) &&
           idle_cycles < WATCHDOG_LIMIT)
      @(negedge clk);

    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: %0d cycles without a transfer, %0d of %0d frames sent",
               idle_cycles, frames_sent, frame_total);
      $display("slot_counter_assembler_core verification failed");
      $finish;
    end else begin
      repeat (DRAIN_CYCLES) @(negedge clk);
      if (expected_results.size() != 0) mismatches++;

      $display("Run covered %0d frames: %0d counter sets completed, %0d decrypt requests,",
               frames_sent, sets_done, requests_done);
      $display("a %0d-cycle receiver hold-off, %0d mismatches",
               HOLDOFF_CYCLES, mismatches);
      if (mismatches == 0) begin
        $display("slot_counter_assembler_core verification clean");
      end else begin
        $display("slot_counter_assembler_core verification failed");
      end
      $finish;
    end
  end

endmodule
